// File: rtl/core/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and constants for the debounced tap classifier: register
// indexes, register reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package dtc_pkg;

  // configuration port geometry
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TAP_MS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINED_SOURCES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_PIN_ENABLED  = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_TAP_MS_RST = 16'd1000;

  // reported seconds field
  localparam int              SECS_W   = 16;
  localparam logic [SECS_W-1:0] SECS_MAX = '1;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_tap_ms;
    logic             combined_sources;
    logic             ext_pin_enabled;
  } cfg_t;

endpackage

// File: rtl/core/dtc_core.sv
// ----------------------------------------------------------------------------
// dtc_core
// Tick state: debounce counter, press timer, sticky tap flags, seconds
// counter and coordinate latch. Result is formed combinationally from the
// current state and one registered tick; state updates on step.
// ----------------------------------------------------------------------------
module dtc_core
  import dtc_pkg::*;
#(
  parameter int TIMER_WIDTH      = 16,
  parameter int COORD_WIDTH      = 12,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  cfg_t                   cfg,
  input  logic                   pin_level,
  input  logic                   screen_touched,
  input  logic [COORD_WIDTH-1:0] touch_x,
  input  logic [COORD_WIDTH-1:0] touch_y,
  input  logic                   boot_level,
  input  logic                   clear_short,
  input  logic                   clear_long,
  output logic                   res_touched,
  output logic                   res_short_tap,
  output logic                   res_long_tap,
  output logic [SECS_W-1:0]      res_secs,
  output logic [COORD_WIDTH-1:0] res_point_x,
  output logic [COORD_WIDTH-1:0] res_point_y
);

  localparam int MS_W  = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
  localparam logic [MS_W:0]          MS_WRAP   = (MS_W+1)'(TICKS_PER_SECOND);

  logic                   prev_level_r, prev_level_nxt;
  logic                   deb_level_r, deb_level_nxt;
  logic [TIMER_WIDTH-1:0] stable_r, stable_nxt;
  logic [TIMER_WIDTH-1:0] press_r, press_nxt;
  logic                   short_r, short_nxt;
  logic                   long_r, long_nxt;
  logic                   tap_seen_r, tap_seen_nxt;
  logic [MS_W-1:0]        ms_r, ms_nxt;
  logic [TIMER_WIDTH-1:0] secs_r, secs_nxt;
  logic [COORD_WIDTH-1:0] x_r, x_nxt;
  logic [COORD_WIDTH-1:0] y_r, y_nxt;

  logic                   level;
  logic                   accept;
  logic [MS_W:0]          ms_inc;
  logic [CMP_W-1:0]       secs_wide;

  always_comb begin
    prev_level_nxt = prev_level_r;
    deb_level_nxt  = deb_level_r;
    stable_nxt     = stable_r;
    press_nxt      = press_r;
    short_nxt      = short_r;
    long_nxt       = long_r;
    tap_seen_nxt   = tap_seen_r;
    ms_nxt         = ms_r;
    secs_nxt       = secs_r;
    x_nxt          = x_r;
    y_nxt          = y_r;

    // seconds since last tap
    ms_inc = {1'b0, ms_r} + 1'b1;
    if (tap_seen_r) begin
      if (ms_inc >= MS_WRAP) begin
        ms_nxt = '0;
        if (secs_r != TIMER_MAX) secs_nxt = secs_r + 1'b1;
      end else begin
        ms_nxt = ms_inc[MS_W-1:0];
      end
    end

    if (deb_level_r && (press_r != TIMER_MAX)) press_nxt = press_r + 1'b1;

    // raw pressed level
    if (cfg.combined_sources) begin
      level = screen_touched | ~boot_level | (cfg.ext_pin_enabled & pin_level);
      if (screen_touched) begin
        x_nxt = touch_x;
        y_nxt = touch_y;
      end
    end else begin
      level = pin_level;
    end

    if (level != prev_level_r) stable_nxt = '0;
    else if (stable_r != TIMER_MAX) stable_nxt = stable_r + 1'b1;
    prev_level_nxt = level;

    accept = (CMP_W'(stable_nxt) > CMP_W'(cfg.debounce_ms)) && (level != deb_level_r);
    if (accept) begin
      deb_level_nxt = level;
      if (level) begin
        press_nxt = '0;
        short_nxt = 1'b0;
        long_nxt  = 1'b0;
      end else begin
        if (CMP_W'(press_nxt) < CMP_W'(cfg.long_tap_ms)) short_nxt = 1'b1;
        else long_nxt = 1'b1;
        tap_seen_nxt = 1'b1;
        ms_nxt       = '0;
        secs_nxt     = '0;
      end
    end

    // result: flags before this tick's clears
    secs_wide = tap_seen_nxt ? CMP_W'(secs_nxt) : '0;
    if (secs_wide > CMP_W'(SECS_MAX)) secs_wide = CMP_W'(SECS_MAX);
  end

  assign res_touched   = deb_level_nxt;
  assign res_short_tap = short_nxt;
  assign res_long_tap  = long_nxt;
  assign res_secs      = secs_wide[SECS_W-1:0];
  assign res_point_x   = x_nxt;
  assign res_point_y   = y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      deb_level_r  <= 1'b0;
      stable_r     <= '0;
      press_r      <= '0;
      short_r      <= 1'b0;
      long_r       <= 1'b0;
      tap_seen_r   <= 1'b0;
      ms_r         <= '0;
      secs_r       <= '0;
      x_r          <= '0;
      y_r          <= '0;
    end else if (step) begin
      prev_level_r <= prev_level_nxt;
      deb_level_r  <= deb_level_nxt;
      stable_r     <= stable_nxt;
      press_r      <= press_nxt;
      short_r      <= short_nxt & ~clear_short;
      long_r       <= long_nxt & ~clear_long;
      tap_seen_r   <= tap_seen_nxt;
      ms_r         <= ms_nxt;
      secs_r       <= secs_nxt;
      x_r          <= x_nxt;
      y_r          <= y_nxt;
    end
  end

  // a press clears both flags and a release sets exactly one
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(short_r && long_r))
    else $error("short and long tap flags both set");

  // seconds only run once a tap has been seen
  a_secs_after_tap: assert property (@(posedge clk) disable iff (!rst_n)
    !tap_seen_r |-> (secs_r == '0) && (ms_r == '0))
    else $error("seconds counter running before first tap");

  // a rising debounced level always starts a fresh press
  a_press_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && accept && level |=> (press_r == '0) && !short_r && !long_r)
    else $error("press acceptance did not restart press state");

endmodule

// File: rtl/core/debounced_tap_classifier.sv
// ----------------------------------------------------------------------------
// debounced_tap_classifier
// Millisecond-tick button/touch debouncer with short/long tap detection.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick of sampled levels; every
// tick produces exactly one result transaction. The block takes one
// transaction per clock while in_stall is low. The tick is captured in the
// input register at acceptance and its result is loaded into the result
// register when that register is empty or draining; the result is then
// held there while out_stall is high. The state update between the two
// registers is a single pass of counter increments and compares, so nothing
// limits the rate but the result channel's stall. Configuration is a plain
// write port (cfg_wr_en, cfg_index, cfg_wdata) and must only be written while
// no tick is in flight.
// ----------------------------------------------------------------------------
module debounced_tap_classifier
  import dtc_pkg::*;
#(
  parameter int TIMER_WIDTH      = 16,
  parameter int COORD_WIDTH      = 12,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                   clk,
  input  logic                   rst_n,

  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,

  // tick input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_pin_level,
  input  logic                   in_screen_touched,
  input  logic [COORD_WIDTH-1:0] in_touch_x,
  input  logic [COORD_WIDTH-1:0] in_touch_y,
  input  logic                   in_boot_level,
  input  logic                   in_clear_short,
  input  logic                   in_clear_long,

  // result
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_touched,
  output logic                   out_short_tap,
  output logic                   out_long_tap,
  output logic [SECS_W-1:0]      out_secs_since_tap,
  output logic [COORD_WIDTH-1:0] out_point_x,
  output logic [COORD_WIDTH-1:0] out_point_y
);

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= DEBOUNCE_MS_RST;
      cfg_r.long_tap_ms      <= LONG_TAP_MS_RST;
      cfg_r.combined_sources <= 1'b0;
      cfg_r.ext_pin_enabled  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:      cfg_r.debounce_ms      <= cfg_wdata;
        REG_LONG_TAP_MS:      cfg_r.long_tap_ms      <= cfg_wdata;
        REG_COMBINED_SOURCES: cfg_r.combined_sources <= cfg_wdata[0];
        REG_EXT_PIN_ENABLED:  cfg_r.ext_pin_enabled  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic                   s1_valid_r;
  logic                   s1_pin_r, s1_scr_r, s1_boot_r, s1_clr_s_r, s1_clr_l_r;
  logic [COORD_WIDTH-1:0] s1_x_r, s1_y_r;
  logic                   in_take;
  logic                   step;

  // s1 moves on whenever the result register is empty or draining
  assign step     = s1_valid_r && (!out_valid || !out_stall);
  // stall only when both stages hold a transaction and the sink holds off
  assign in_stall = s1_valid_r && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take || (s1_valid_r && !step);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pin_r   <= in_pin_level;
      s1_scr_r   <= in_screen_touched;
      s1_x_r     <= in_touch_x;
      s1_y_r     <= in_touch_y;
      s1_boot_r  <= in_boot_level;
      s1_clr_s_r <= in_clear_short;
      s1_clr_l_r <= in_clear_long;
    end
  end

  // tick state and result logic
  logic                   res_touched, res_short, res_long;
  logic [SECS_W-1:0]      res_secs;
  logic [COORD_WIDTH-1:0] res_x, res_y;

  dtc_core #(
    .TIMER_WIDTH      (TIMER_WIDTH),
    .COORD_WIDTH      (COORD_WIDTH),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .cfg            (cfg_r),
    .pin_level      (s1_pin_r),
    .screen_touched (s1_scr_r),
    .touch_x        (s1_x_r),
    .touch_y        (s1_y_r),
    .boot_level     (s1_boot_r),
    .clear_short    (s1_clr_s_r),
    .clear_long     (s1_clr_l_r),
    .res_touched    (res_touched),
    .res_short_tap  (res_short),
    .res_long_tap   (res_long),
    .res_secs       (res_secs),
    .res_point_x    (res_x),
    .res_point_y    (res_y)
  );

  // result register
  logic                   out_valid_r;
  logic                   out_touched_r, out_short_r, out_long_r;
  logic [SECS_W-1:0]      out_secs_r;
  logic [COORD_WIDTH-1:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= step || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_touched_r <= res_touched;
      out_short_r   <= res_short;
      out_long_r    <= res_long;
      out_secs_r    <= res_secs;
      out_x_r       <= res_x;
      out_y_r       <= res_y;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_touched        = out_touched_r;
  assign out_short_tap      = out_short_r;
  assign out_long_tap       = out_long_r;
  assign out_secs_since_tap = out_secs_r;
  assign out_point_x        = out_x_r;
  assign out_point_y        = out_y_r;

  // a tick moved out of s1 always lands in the result register
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("stepped transaction lost before result register");

  // the input only stalls when both stages are occupied
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

  // a result never reports both tap kinds
  a_out_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_short_r && out_long_r))
    else $error("result reports short and long tap together");

endmodule
